### rtl/mhi_pkg.sv
// Shared types and codes for the binary max-heap insert block.
// No dependencies; mhi_out_if, mhi_seq and max_heap_insert import this package.
`default_nettype none

package mhi_pkg;

    // Operation carried by an input item.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Status reported with each result item.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

`default_nettype wire

### rtl/mhi_in_if.sv
// Input channel of the heap block: valid/ready handshake plus the item fields.
// Depends on nothing but its own parameters.
`default_nettype none

interface mhi_in_if #(
    parameter int IDX_W     = 5,
    parameter int KEY_WIDTH = 16
);
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic signed [KEY_WIDTH-1:0] value;
    logic        [IDX_W-1:0]     index;

    modport source (output valid, output opcode, output value, output index, input ready);
    modport sink   (input valid, input opcode, input value, input index, output ready);
endinterface

`default_nettype wire

### rtl/mhi_out_if.sv
// Result channel of the heap block: valid/ready handshake plus the result fields.
// Depends on mhi_pkg for the status type.
`default_nettype none

interface mhi_out_if
    import mhi_pkg::*;
#(
    parameter int IDX_W     = 5,
    parameter int CNT_W     = 6,
    parameter int KEY_WIDTH = 16
);
    logic                        valid;
    logic                        ready;
    t_status                     status;
    logic        [IDX_W-1:0]     position;
    logic        [CNT_W-1:0]     entry_count;
    logic signed [KEY_WIDTH-1:0] read_data;

    modport source (output valid, output status, output position, output entry_count,
                    output read_data, input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    input read_data, output ready);
endinterface

`default_nettype wire

### rtl/mhi_ram.sv
// Heap key storage: one write port and one read port with registered read data.
// Depends on nothing; used by the max_heap_insert top level.
`default_nettype none

module mhi_ram #(
    parameter int DEPTH     = 32,
    parameter int KEY_WIDTH = 16,
    parameter int IDX_W     = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [IDX_W-1:0]     i_wr_addr,
    input  wire logic [KEY_WIDTH-1:0] i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [IDX_W-1:0]     i_rd_addr,
    output logic      [KEY_WIDTH-1:0] o_rd_data
);

    logic [KEY_WIDTH-1:0] r_mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data appears the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/mhi_seq.sv
// Sift-up sequencer: walks from the free slot toward the root, one level per
// cycle, using a single signed compare against the parent read from storage.
// Depends on mhi_pkg; drives the mhi_ram ports.
`default_nettype none

module mhi_seq
    import mhi_pkg::*;
#(
    parameter int DEPTH     = 32,
    parameter int KEY_WIDTH = 16,
    parameter int IDX_W     = 5,
    parameter int CNT_W     = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Item side
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_opcode,
    input  wire logic [KEY_WIDTH-1:0] i_value,
    input  wire logic [IDX_W-1:0]     i_index,
    // Result side
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output t_status                   o_status,
    output logic      [IDX_W-1:0]     o_position,
    output logic      [CNT_W-1:0]     o_count,
    output logic      [KEY_WIDTH-1:0] o_read_data,
    // Storage side
    output logic                      o_rd_en,
    output logic      [IDX_W-1:0]     o_rd_addr,
    input  wire logic [KEY_WIDTH-1:0] i_rd_data,
    output logic                      o_wr_en,
    output logic      [IDX_W-1:0]     o_wr_addr,
    output logic      [KEY_WIDTH-1:0] o_wr_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_FETCH = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [CNT_W-1:0]     r_count, n_count;
    t_status              r_status, n_status;
    logic [IDX_W-1:0]     r_position, n_position;
    logic [CNT_W-1:0]     r_res_count, n_res_count;
    logic [KEY_WIDTH-1:0] r_read_data, n_read_data;

    logic [IDX_W-1:0]     free_slot;
    logic [IDX_W-1:0]     parent;
    logic                 parent_holds;

    // Parent of a slot is (slot - 1) / 2.
    function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] slot);
        logic [IDX_W-1:0] dec;
        dec = slot - 1'b1;
        return dec >> 1;
    endfunction

    assign free_slot    = r_count[IDX_W-1:0];
    assign parent       = parent_of(r_slot);
    // Equal keys stop the walk: the parent stays above the new key.
    assign parent_holds = ($signed(i_rd_data) >= $signed(r_key));

    // Next-state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_key       = r_key;
        n_count     = r_count;
        n_status    = r_status;
        n_position  = r_position;
        n_res_count = r_res_count;
        n_read_data = r_read_data;
        o_rd_en     = 1'b0;
        o_rd_addr   = '0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_slot;
        o_wr_data   = r_key;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_position  = '0;
                    n_read_data = '0;
                    n_res_count = r_count;
                    if (i_opcode == OP_PUSH) begin
                        if (r_count == FULL_COUNT) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_slot    = free_slot;
                            n_key     = i_value;
                            o_rd_en   = (r_count != '0);
                            o_rd_addr = parent_of(free_slot);
                            n_state   = S_LOOK;
                        end
                    end else begin
                        if (CNT_W'(i_index) < r_count) begin
                            o_rd_en   = 1'b1;
                            o_rd_addr = i_index;
                            n_state   = S_FETCH;
                        end else begin
                            n_status = ST_EMPTY;
                            n_state  = S_DONE;
                        end
                    end
                end
            end

            S_LOOK: begin
                if ((r_slot == '0) || parent_holds) begin
                    // The key settles here.
                    o_wr_en     = 1'b1;
                    n_count     = r_count + 1'b1;
                    n_res_count = r_count + 1'b1;
                    n_status    = ST_OK;
                    n_position  = r_slot;
                    n_state     = S_DONE;
                end else begin
                    // Move the smaller parent down and climb one level.
                    o_wr_en   = 1'b1;
                    o_wr_data = i_rd_data;
                    n_slot    = parent;
                    o_rd_en   = (parent != '0);
                    o_rd_addr = parent_of(parent);
                end
            end

            S_FETCH: begin
                n_status    = ST_OK;
                n_read_data = i_rd_data;
                n_state     = S_DONE;
            end

            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Walk and result payload.
    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_key       <= n_key;
        r_status    <= n_status;
        r_position  <= n_position;
        r_res_count <= n_res_count;
        r_read_data <= n_read_data;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_status    = r_status;
    assign o_position  = r_position;
    assign o_count     = r_res_count;
    assign o_read_data = r_read_data;

endmodule

`default_nettype wire

### rtl/max_heap_insert.sv
// Binary max-heap with sift-up insertion. A push climbs one level per step from the free slot
// toward the root, up to log2(DEPTH) levels, and a read fetches one stored key; a push to a
// full heap is refused. The next item is taken only after the result of the last one is handed
// on to the result register, so items never overlap. The sift-up loop over the single storage
// read port sets the rate. Reset (synchronous, active low) empties the heap and the result
// register; the key storage itself is not cleared.
`default_nettype none

module max_heap_insert
    import mhi_pkg::*;
#(
    parameter int DEPTH     = 32,
    parameter int KEY_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mhi_in_if.sink    i_in,
    mhi_out_if.source o_res
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 seq_res_valid;
    logic                 seq_res_ready;
    t_status              seq_status;
    logic [IDX_W-1:0]     seq_position;
    logic [CNT_W-1:0]     seq_count;
    logic [KEY_WIDTH-1:0] seq_read_data;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [KEY_WIDTH-1:0] wr_data;

    logic                 r_valid;
    t_status              r_status;
    logic [IDX_W-1:0]     r_position;
    logic [CNT_W-1:0]     r_count;
    logic [KEY_WIDTH-1:0] r_read_data;

    mhi_seq #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_opcode    (i_in.opcode),
        .i_value     (i_in.value),
        .i_index     (i_in.index),
        .o_res_valid (seq_res_valid),
        .i_res_ready (seq_res_ready),
        .o_status    (seq_status),
        .o_position  (seq_position),
        .o_count     (seq_count),
        .o_read_data (seq_read_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    mhi_ram #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .IDX_W     (IDX_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: takes a new result item when empty or being drained.
    assign seq_res_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (seq_res_ready) begin
            r_valid <= seq_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res_valid && seq_res_ready) begin
            r_status    <= seq_status;
            r_position  <= seq_position;
            r_count     <= seq_count;
            r_read_data <= seq_read_data;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.status      = r_status;
    assign o_res.position    = r_position;
    assign o_res.entry_count = r_count;
    assign o_res.read_data   = r_read_data;

endmodule

`default_nettype wire
